>>> sv/tdt_pkg.sv
`default_nettype none

package tdt_pkg;

  // Number of DFA states the tables are built for
  localparam int NUM_STATES_DEF = 16;

  // Input command codes
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_DEFINE = 2'd1;
  localparam logic [1:0] CMD_TEXT   = 2'd2;
  localparam logic [1:0] CMD_END    = 2'd3;

  // State kinds; the fourth code behaves as intermediate
  localparam logic [1:0] KIND_INITIAL      = 2'd0;
  localparam logic [1:0] KIND_INTERMEDIATE = 2'd1;
  localparam logic [1:0] KIND_FINAL        = 2'd2;

  // Result kinds
  localparam logic RES_TOKEN = 1'b0;
  localparam logic RES_ERROR = 1'b1;

  // Edge labels of the byte classes and of the fallback edge
  localparam logic [7:0] LBL_DIGIT  = 8'h01;
  localparam logic [7:0] LBL_BLANK  = 8'h02;
  localparam logic [7:0] LBL_LETTER = 8'h07;
  localparam logic [7:0] LBL_OTHER  = 8'h0B;

  localparam logic [7:0] BYTE_NEWLINE = 8'h0A;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] id;
  } state_info_t;

  // Map a text byte to the label of its class
  function automatic logic [7:0] byte_class(input logic [7:0] b);
    logic is_letter;
    logic is_digit;
    logic is_blank;
    is_letter = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    is_digit  = (b >= 8'h30) && (b <= 8'h39);
    // space, tab, line feed, carriage return
    is_blank  = (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
    if (is_letter) begin
      return LBL_LETTER;
    end else if (is_digit) begin
      return LBL_DIGIT;
    end else if (is_blank) begin
      return LBL_BLANK;
    end
    return b;
  endfunction

  // Saturating 16-bit increment
  function automatic logic [15:0] inc_sat(input logic [15:0] v);
    if (v == CNT_MAX) begin
      return CNT_MAX;
    end
    return v + 16'd1;
  endfunction

endpackage

`default_nettype wire

>>> sv/tdt_trans_mem.sv
`default_nettype none

// Transition table: one entry per (state, label), valid bit over next state
module tdt_trans_mem
  import tdt_pkg::*;
#(
  parameter int NUM_STATES = NUM_STATES_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [$clog2(NUM_STATES * 256)-1:0]     waddr,
  input  wire logic [$clog2(NUM_STATES):0]             wdata,
  input  wire logic [$clog2(NUM_STATES * 256)-1:0]     raddr,
  output logic      [$clog2(NUM_STATES):0]             rdata
);

  localparam int SW     = $clog2(NUM_STATES);
  localparam int TDEPTH = NUM_STATES * 256;

  logic [SW:0] mem [TDEPTH];
  logic [SW:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> sv/tdt_state_mem.sv
`default_nettype none

// Per-state kind and token id; unwritten entries read as intermediate
module tdt_state_mem
  import tdt_pkg::*;
#(
  parameter int NUM_STATES = NUM_STATES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          we,
  input  wire logic [$clog2(NUM_STATES)-1:0] waddr,
  input  wire state_info_t                   wdata,
  input  wire logic [$clog2(NUM_STATES)-1:0] raddr,
  output state_info_t                        rdata
);

  state_info_t             mem [NUM_STATES];
  logic [NUM_STATES-1:0]   vld_r;
  state_info_t             rd_info_r;
  logic                    rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      rd_vld_r <= vld_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_info_r <= mem[raddr];
  end

  always_comb begin
    rdata      = rd_info_r;
    rdata.kind = rd_vld_r ? rd_info_r.kind : KIND_INTERMEDIATE;
  end

endmodule

`default_nettype wire

>>> sv/table_dfa_tokenizer_unit.sv
`default_nettype none

// Table-driven DFA lexer with maximal munch. Load transactions (command 0) write one edge
// of the transition table, define transactions (command 1) set the kind and token id of a
// state. Each text byte (command 2) is mapped to a class label (letter, digit, blank, or
// the byte itself) and the walk follows that edge, or else the "other" edge; each step
// waits on the registered reads of the transition memory (class edge, then other edge)
// and then of the state memory for the landing state. A byte on which the walk is stuck
// reads the current state's kind and either reports an error, or reports the token and
// walks the byte again from the start state; either way it may wait for the result
// register to drain. End of text (command 3) returns the walk and position to the start,
// after first reporting any open lexeme. After reset the transition memory is swept clear,
// one entry a cycle, over all NUM_STATES*256 entries (4096 by default), during which no
// input transaction is taken; start_state writes are accepted at any time but must only be
// issued while the block is idle. Results leave through a one-entry output register, and
// the next input transaction is taken while a result still waits there.
module table_dfa_tokenizer_unit
  import tdt_pkg::*;
#(
  parameter int NUM_STATES = NUM_STATES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Start state register write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data,    // start_state
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,    // char_byte[7:0], from_state[11:8], to_state[15:12],
                                        // state_kind[17:16], token_id[33:18], zero[39:34]
  input  wire logic [1:0]  in_tuser,    // command[1:0]
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,   // found_id[15:0], start_line[31:16],
                                        // start_col[47:32], lexeme_length[63:48]
  output logic             out_tuser,   // result_kind
  output logic             out_tlast    // last
);

  localparam int SW     = $clog2(NUM_STATES);
  localparam int TDEPTH = NUM_STATES * 256;
  localparam int AW     = $clog2(TDEPTH);

  // Control sequencer states
  localparam logic [3:0] S_CLR  = 4'd0;  // sweep the transition memory
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_T1   = 4'd2;  // class edge read returns
  localparam logic [3:0] S_T2   = 4'd3;  // other edge read returns
  localparam logic [3:0] S_LAND = 4'd4;  // landing state kind returns
  localparam logic [3:0] S_STK  = 4'd5;  // stuck: current state kind returns
  localparam logic [3:0] S_ISS  = 4'd6;  // reissue the byte from the start state
  localparam logic [3:0] S_EOT  = 4'd7;  // end of text: current state kind returns
  localparam logic [3:0] S_EM1  = 4'd8;  // hand over the held result
  localparam logic [3:0] S_EM2  = 4'd9;  // hand over the trailing error

  // Input fields
  logic [1:0]  in_cmd;
  logic [7:0]  in_char;
  logic [3:0]  in_from;
  logic [3:0]  in_to;
  logic [1:0]  in_kind;
  logic [15:0] in_tid;

  assign in_cmd  = in_tuser;
  assign in_char = in_tdata[7:0];
  assign in_from = in_tdata[11:8];
  assign in_to   = in_tdata[15:12];
  assign in_kind = in_tdata[17:16];
  assign in_tid  = in_tdata[33:18];

  // Control registers
  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [3:0]    start_r, start_nxt;
  logic [SW-1:0] cur_r, cur_nxt;
  logic [15:0]   line_r, line_nxt;
  logic [15:0]   col_r, col_nxt;
  logic [15:0]   lex_line_r, lex_line_nxt;
  logic [15:0]   lex_col_r, lex_col_nxt;
  logic [15:0]   lex_cnt_r, lex_cnt_nxt;
  logic          pend_r, pend_nxt;
  logic          rep_r, rep_nxt;
  logic          err2_r, err2_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Payload registers
  logic [7:0]    lbl_r, lbl_nxt;
  logic [SW-1:0] dest_r, dest_nxt;
  logic [15:0]   pos_line_r, pos_line_nxt;
  logic [15:0]   pos_col_r, pos_col_nxt;
  logic          tok_kind_r, tok_kind_nxt;
  logic [15:0]   tok_id_r, tok_id_nxt;
  logic [15:0]   tok_line_r, tok_line_nxt;
  logic [15:0]   tok_col_r, tok_col_nxt;
  logic [15:0]   tok_len_r, tok_len_nxt;
  logic          out_kind_r, out_kind_nxt;
  logic [15:0]   out_id_r, out_id_nxt;
  logic [15:0]   out_line_r, out_line_nxt;
  logic [15:0]   out_col_r, out_col_nxt;
  logic [15:0]   out_len_r, out_len_nxt;
  logic          out_last_r, out_last_nxt;

  // Memory ports
  logic          trans_we;
  logic [AW-1:0] trans_waddr;
  logic [SW:0]   trans_wdata;
  logic [AW-1:0] trans_raddr;
  logic [SW:0]   trans_rdata;
  logic          smem_we;
  logic [SW-1:0] smem_waddr;
  state_info_t   smem_wdata;
  logic [SW-1:0] smem_raddr;
  state_info_t   smem_rdata;

  logic          in_acc;
  logic          slot_free;
  logic          from_ok;
  logic          to_ok;
  logic [7:0]    in_lbl;
  logic [SW-1:0] start_idx;
  logic [SW-1:0] start_mod [16];

  // Start state reduced modulo the number of states, worked out per code at elaboration
  for (genvar gi = 0; gi < 16; gi++) begin : g_start_mod
    assign start_mod[gi] = SW'(gi % NUM_STATES);
  end

  assign start_idx = start_mod[start_r];
  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign from_ok   = (int'(in_from) < NUM_STATES);
  assign to_ok     = (int'(in_to) < NUM_STATES);
  assign in_lbl    = byte_class(in_char);

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  tdt_trans_mem #(
    .NUM_STATES (NUM_STATES)
  ) u_trans_mem (
    .clk   (clk),
    .we    (trans_we),
    .waddr (trans_waddr),
    .wdata (trans_wdata),
    .raddr (trans_raddr),
    .rdata (trans_rdata)
  );

  tdt_state_mem #(
    .NUM_STATES (NUM_STATES)
  ) u_state_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (smem_we),
    .waddr (smem_waddr),
    .wdata (smem_wdata),
    .raddr (smem_raddr),
    .rdata (smem_rdata)
  );

  always_comb begin
    // Hold everything by default
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    start_nxt     = start_r;
    cur_nxt       = cur_r;
    line_nxt      = line_r;
    col_nxt       = col_r;
    lex_line_nxt  = lex_line_r;
    lex_col_nxt   = lex_col_r;
    lex_cnt_nxt   = lex_cnt_r;
    pend_nxt      = pend_r;
    rep_nxt       = rep_r;
    err2_nxt      = err2_r;
    out_valid_nxt = out_valid_r && !out_tready;

    lbl_nxt       = lbl_r;
    dest_nxt      = dest_r;
    pos_line_nxt  = pos_line_r;
    pos_col_nxt   = pos_col_r;
    tok_kind_nxt  = tok_kind_r;
    tok_id_nxt    = tok_id_r;
    tok_line_nxt  = tok_line_r;
    tok_col_nxt   = tok_col_r;
    tok_len_nxt   = tok_len_r;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_line_nxt  = out_line_r;
    out_col_nxt   = out_col_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;

    trans_we      = 1'b0;
    trans_waddr   = {SW'(in_from), in_char};
    trans_wdata   = {1'b1, SW'(in_to)};
    trans_raddr   = {cur_r, lbl_r};
    smem_we       = 1'b0;
    smem_waddr    = SW'(in_from);
    smem_wdata    = '{kind: in_kind, id: in_tid};
    smem_raddr    = cur_r;

    case (state_r)
      S_CLR: begin
        // Invalidate one edge per cycle
        trans_we    = 1'b1;
        trans_waddr = clr_cnt_r;
        trans_wdata = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(TDEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_LOAD: begin
              trans_we = from_ok && to_ok;
            end
            CMD_DEFINE: begin
              smem_we = from_ok;
            end
            CMD_TEXT: begin
              // Advance the position once per byte; reprocessing never moves it
              lbl_nxt      = in_lbl;
              pos_line_nxt = line_r;
              pos_col_nxt  = col_r;
              if (in_char == BYTE_NEWLINE) begin
                line_nxt = inc_sat(line_r);
                col_nxt  = 16'd1;
              end else begin
                col_nxt  = inc_sat(col_r);
              end
              trans_raddr = {cur_r, in_lbl};
              rep_nxt     = 1'b0;
              state_nxt   = S_T1;
            end
            CMD_END: begin
              if (pend_r) begin
                state_nxt = S_EOT;
              end else begin
                line_nxt     = 16'd1;
                col_nxt      = 16'd1;
                cur_nxt      = start_idx;
                lex_line_nxt = 16'd1;
                lex_col_nxt  = 16'd1;
                lex_cnt_nxt  = '0;
                pend_nxt     = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_T1: begin
        if (trans_rdata[SW]) begin
          dest_nxt   = trans_rdata[SW-1:0];
          smem_raddr = trans_rdata[SW-1:0];
          state_nxt  = S_LAND;
        end else begin
          trans_raddr = {cur_r, LBL_OTHER};
          state_nxt   = S_T2;
        end
      end

      S_T2: begin
        if (trans_rdata[SW]) begin
          dest_nxt   = trans_rdata[SW-1:0];
          smem_raddr = trans_rdata[SW-1:0];
          state_nxt  = S_LAND;
        end else if (rep_r) begin
          // Stuck again on the reprocessed byte: token, then error, drop the byte
          err2_nxt     = 1'b1;
          cur_nxt      = start_idx;
          lex_line_nxt = line_r;
          lex_col_nxt  = col_r;
          lex_cnt_nxt  = '0;
          pend_nxt     = 1'b0;
          state_nxt    = S_EM1;
        end else begin
          state_nxt = S_STK;
        end
      end

      S_LAND: begin
        cur_nxt = dest_r;
        if (smem_rdata.kind == KIND_INITIAL) begin
          lex_line_nxt = line_r;
          lex_col_nxt  = col_r;
          pend_nxt     = 1'b0;
        end else begin
          pend_nxt = 1'b1;
        end
        if (lbl_r != LBL_BLANK) begin
          lex_cnt_nxt = inc_sat(lex_cnt_r);
        end
        if (rep_r) begin
          err2_nxt  = 1'b0;
          state_nxt = S_EM1;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_STK: begin
        tok_line_nxt = lex_line_r;
        tok_col_nxt  = lex_col_r;
        tok_len_nxt  = lex_cnt_r;
        if (smem_rdata.kind == KIND_FINAL) begin
          // Hold the token and walk the byte again from the start state
          tok_kind_nxt = RES_TOKEN;
          tok_id_nxt   = smem_rdata.id;
          cur_nxt      = start_idx;
          lex_line_nxt = pos_line_r;
          lex_col_nxt  = pos_col_r;
          lex_cnt_nxt  = '0;
          pend_nxt     = 1'b0;
          rep_nxt      = 1'b1;
          state_nxt    = S_ISS;
        end else begin
          // Stuck in a non-final state: error and drop the byte
          tok_kind_nxt = RES_ERROR;
          tok_id_nxt   = '0;
          err2_nxt     = 1'b0;
          cur_nxt      = start_idx;
          lex_line_nxt = line_r;
          lex_col_nxt  = col_r;
          lex_cnt_nxt  = '0;
          pend_nxt     = 1'b0;
          state_nxt    = S_EM1;
        end
      end

      S_ISS: begin
        state_nxt = S_T1;
      end

      S_EOT: begin
        tok_line_nxt = lex_line_r;
        tok_col_nxt  = lex_col_r;
        tok_len_nxt  = lex_cnt_r;
        if (smem_rdata.kind == KIND_FINAL) begin
          tok_kind_nxt = RES_TOKEN;
          tok_id_nxt   = smem_rdata.id;
        end else begin
          tok_kind_nxt = RES_ERROR;
          tok_id_nxt   = '0;
        end
        err2_nxt     = 1'b0;
        line_nxt     = 16'd1;
        col_nxt      = 16'd1;
        cur_nxt      = start_idx;
        lex_line_nxt = 16'd1;
        lex_col_nxt  = 16'd1;
        lex_cnt_nxt  = '0;
        pend_nxt     = 1'b0;
        state_nxt    = S_EM1;
      end

      S_EM1: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = tok_kind_r;
          out_id_nxt    = tok_id_r;
          out_line_nxt  = tok_line_r;
          out_col_nxt   = tok_col_r;
          out_len_nxt   = tok_len_r;
          out_last_nxt  = !err2_r;
          rep_nxt       = 1'b0;
          state_nxt     = err2_r ? S_EM2 : S_IDLE;
        end
      end

      S_EM2: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = RES_ERROR;
          out_id_nxt    = '0;
          out_line_nxt  = pos_line_r;
          out_col_nxt   = pos_col_r;
          out_len_nxt   = '0;
          out_last_nxt  = 1'b1;
          err2_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Start state write: move the walk at once and drop any open lexeme
    if (cfg_valid && cfg_ready) begin
      start_nxt    = cfg_data;
      cur_nxt      = start_mod[cfg_data];
      lex_line_nxt = line_r;
      lex_col_nxt  = col_r;
      lex_cnt_nxt  = '0;
      pend_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      start_r     <= '0;
      cur_r       <= '0;
      line_r      <= 16'd1;
      col_r       <= 16'd1;
      lex_line_r  <= 16'd1;
      lex_col_r   <= 16'd1;
      lex_cnt_r   <= '0;
      pend_r      <= 1'b0;
      rep_r       <= 1'b0;
      err2_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      start_r     <= start_nxt;
      cur_r       <= cur_nxt;
      line_r      <= line_nxt;
      col_r       <= col_nxt;
      lex_line_r  <= lex_line_nxt;
      lex_col_r   <= lex_col_nxt;
      lex_cnt_r   <= lex_cnt_nxt;
      pend_r      <= pend_nxt;
      rep_r       <= rep_nxt;
      err2_r      <= err2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lbl_r      <= lbl_nxt;
    dest_r     <= dest_nxt;
    pos_line_r <= pos_line_nxt;
    pos_col_r  <= pos_col_nxt;
    tok_kind_r <= tok_kind_nxt;
    tok_id_r   <= tok_id_nxt;
    tok_line_r <= tok_line_nxt;
    tok_col_r  <= tok_col_nxt;
    tok_len_r  <= tok_len_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_line_r <= out_line_nxt;
    out_col_r  <= out_col_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_len_r, out_col_r, out_line_r, out_id_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // Positions count from one and saturate, so they never wrap to zero
  a_pos_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    (line_r != 16'd0) && (col_r != 16'd0) && (lex_line_r != 16'd0) && (lex_col_r != 16'd0))
    else $error("position counter reached zero");

  // The current state always names an existing state
  a_cur_range : assert property (@(posedge clk) disable iff (!rst_n)
    int'(cur_r) < NUM_STATES)
    else $error("current state out of range");

  // A reprocess is always closed before the next transaction is taken
  a_rep_closed : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !rep_r)
    else $error("reprocess flag left set in idle");

  // A held result handed over is shown on the next cycle
  a_emit_shown : assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EM1 || state_r == S_EM2) && slot_free) |=> out_valid_r)
    else $error("result lost at hand-over");

  // A trailing error is only ever queued behind a token
  a_err2_token : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EM1 && err2_r) |-> (tok_kind_r == RES_TOKEN))
    else $error("trailing error without a token");

endmodule

`default_nettype wire
